// ===== rtl/stq_pkg.sv =====
// Shared types and codes for the sorted timer queue.
package stq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS,
    ST_TICK,
    ST_NAP,
    ST_CMP
  } state_e;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ALERT = 2'd1;
  localparam logic [1:0] KIND_NAP   = 2'd2;

  typedef struct packed {
    logic [31:0] etime;
    logic [7:0]  obj;
  } entry_t;

endpackage

// ===== rtl/stq_mem.sv =====
// Timer entry memory with one write port and one registered read port.
module stq_mem #(
  parameter int Depth = 32,
  parameter int AW    = 5
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  stq_pkg::entry_t       wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output stq_pkg::entry_t       rdata_o
);

  stq_pkg::entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue: control sequencer and result registers.
// The queue holds up to QUEUE_DEPTH timers sorted by expiry second in one entry
// memory. A set transaction makes one pass over the memory that finds and removes
// the object's old timer and, unless the new expiry is zero or the queue is full,
// a second pass that walks from the tail to open a slot for the new one. A tick
// transaction reads entries from the head, one per cycle, giving one alert per cycle
// for each expired timer, then the wait report, then, if any timer expired, a
// compaction pass that moves the remaining entries to the head. Results are strobed
// for exactly one cycle and cannot be held off; busy stays high until the
// transaction is finished, including the compaction pass.
module sorted_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [7:0]  object_id_i,
  input  logic [31:0] expiry_time_i,
  input  logic [31:0] now_time_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_strobe_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  alert_object_o,
  output logic [31:0] alert_time_o,
  output logic        second_end_o,
  output logic [15:0] nap_o,
  output logic        queue_full_o,
  output logic        last_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::state_e state_q, state_d;
  logic [7:0]    obj_q, obj_d;
  logic [31:0]   exp_q, exp_d;
  logic [31:0]   now_q, now_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ra_q, ra_d;
  logic [CW-1:0] k_q, k_d;
  logic          v_q, v_d;
  logic [AW-1:0] di_q, di_d;
  logic          found_q, found_d;
  logic          pv_q, pv_d;
  logic [31:0]   pt_q, pt_d;
  logic [7:0]    po_q, po_d;
  logic          hn_q, hn_d;
  logic [31:0]   nt_q, nt_d;
  logic [15:0]   max_nap_q;

  logic            we;
  logic [AW-1:0]   wa;
  stq_pkg::entry_t wd;
  logic [AW-1:0]   raddr;
  stq_pkg::entry_t rd;
  stq_pkg::entry_t new_entry;
  logic            issue;
  logic            stop;
  logic            placing;
  logic [CW-1:0]   cnt_n;
  logic [31:0]     diff;

  logic          strobe_d, strobe_q;
  logic [1:0]    kind_d, kind_q;
  logic [7:0]    aobj_d, aobj_q;
  logic [31:0]   atime_d, atime_q;
  logic          se_d, se_q;
  logic [15:0]   nap_d, nap_q;
  logic          qf_d, qf_q;
  logic          last_d, last_q;

  stq_mem #(
    .Depth (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign new_entry = '{etime: exp_q, obj: obj_q};
  assign cnt_n     = CW'(cnt_q - CW'(found_q));
  assign diff      = nt_q - now_q;
  assign busy      = (state_q != stq_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    obj_d    = obj_q;
    exp_d    = exp_q;
    now_d    = now_q;
    cnt_d    = cnt_q;
    ra_d     = ra_q;
    k_d      = k_q;
    found_d  = found_q;
    pv_d     = pv_q;
    pt_d     = pt_q;
    po_d     = po_q;
    hn_d     = hn_q;
    nt_d     = nt_q;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    issue    = 1'b0;
    raddr    = '0;
    stop     = 1'b0;
    placing  = 1'b0;
    strobe_d = 1'b0;
    kind_d   = stq_pkg::KIND_ACK;
    aobj_d   = '0;
    atime_d  = '0;
    se_d     = 1'b0;
    nap_d    = '0;
    qf_d     = 1'b0;
    last_d   = 1'b0;

    case (state_q)
      stq_pkg::ST_IDLE: begin
        if (start) begin
          obj_d   = object_id_i;
          exp_d   = expiry_time_i;
          now_d   = now_time_i;
          ra_d    = '0;
          k_d     = '0;
          found_d = 1'b0;
          pv_d    = 1'b0;
          hn_d    = 1'b0;
          state_d = (op_i == stq_pkg::OP_TICK) ? stq_pkg::ST_TICK : stq_pkg::ST_DEL;
        end
      end
      stq_pkg::ST_DEL: begin
        if (v_q) begin
          if (!found_q) begin
            if (rd.obj == obj_q) begin
              found_d = 1'b1;
            end
          end else begin
            we = 1'b1;
            wa = AW'(di_q - AW'(1));
            wd = rd;
          end
        end
        if (ra_q < cnt_q) begin
          issue = 1'b1;
          raddr = ra_q[AW-1:0];
          ra_d  = CW'(ra_q + CW'(1));
        end else if (!v_q) begin
          cnt_d = cnt_n;
          if (exp_q == 32'd0) begin
            strobe_d = 1'b1;
            last_d   = 1'b1;
            state_d  = stq_pkg::ST_IDLE;
          end else if (cnt_n >= CW'(QUEUE_DEPTH)) begin
            strobe_d = 1'b1;
            qf_d     = 1'b1;
            last_d   = 1'b1;
            state_d  = stq_pkg::ST_IDLE;
          end else begin
            ra_d    = cnt_n;
            state_d = stq_pkg::ST_INS;
          end
        end
      end
      stq_pkg::ST_INS: begin
        if (v_q) begin
          we = 1'b1;
          wa = AW'(di_q + AW'(1));
          if (rd.etime > exp_q) begin
            wd = rd;
          end else begin
            wd      = new_entry;
            placing = 1'b1;
          end
        end else if (ra_q == '0) begin
          we      = 1'b1;
          wa      = '0;
          wd      = new_entry;
          placing = 1'b1;
        end
        if (placing) begin
          cnt_d    = CW'(cnt_q + CW'(1));
          strobe_d = 1'b1;
          last_d   = 1'b1;
          state_d  = stq_pkg::ST_IDLE;
        end else if (ra_q != '0) begin
          issue = 1'b1;
          raddr = AW'(ra_q - CW'(1));
          ra_d  = CW'(ra_q - CW'(1));
        end
      end
      stq_pkg::ST_TICK: begin
        if (v_q) begin
          if (rd.etime <= now_q) begin
            if (pv_q) begin
              strobe_d = 1'b1;
              kind_d   = stq_pkg::KIND_ALERT;
              aobj_d   = po_q;
              atime_d  = pt_q;
              se_d     = (pt_q != rd.etime);
            end
            pv_d = 1'b1;
            pt_d = rd.etime;
            po_d = rd.obj;
            k_d  = CW'(k_q + CW'(1));
          end else begin
            stop    = 1'b1;
            hn_d    = 1'b1;
            nt_d    = rd.etime;
            state_d = stq_pkg::ST_NAP;
          end
        end
        if (!stop) begin
          if (ra_q < cnt_q) begin
            issue = 1'b1;
            raddr = ra_q[AW-1:0];
            ra_d  = CW'(ra_q + CW'(1));
          end else if (!v_q) begin
            hn_d    = 1'b0;
            state_d = stq_pkg::ST_NAP;
          end
        end
      end
      stq_pkg::ST_NAP: begin
        strobe_d = 1'b1;
        if (pv_q) begin
          kind_d  = stq_pkg::KIND_ALERT;
          aobj_d  = po_q;
          atime_d = pt_q;
          se_d    = !hn_q || (nt_q != pt_q);
          pv_d    = 1'b0;
        end else begin
          kind_d = stq_pkg::KIND_NAP;
          last_d = 1'b1;
          if (!hn_q || (diff > {16'd0, max_nap_q})) begin
            nap_d = max_nap_q;
          end else begin
            nap_d = diff[15:0];
          end
          if (k_q != '0) begin
            ra_d    = k_q;
            state_d = stq_pkg::ST_CMP;
          end else begin
            state_d = stq_pkg::ST_IDLE;
          end
        end
      end
      stq_pkg::ST_CMP: begin
        if (v_q) begin
          we = 1'b1;
          wa = AW'(di_q - k_q[AW-1:0]);
          wd = rd;
        end
        if (ra_q < cnt_q) begin
          issue = 1'b1;
          raddr = ra_q[AW-1:0];
          ra_d  = CW'(ra_q + CW'(1));
        end else if (!v_q) begin
          cnt_d   = CW'(cnt_q - k_q);
          state_d = stq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stq_pkg::ST_IDLE;
      end
    endcase

    v_d  = issue;
    di_d = raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stq_pkg::ST_IDLE;
      cnt_q     <= '0;
      ra_q      <= '0;
      k_q       <= '0;
      v_q       <= 1'b0;
      found_q   <= 1'b0;
      pv_q      <= 1'b0;
      hn_q      <= 1'b0;
      strobe_q  <= 1'b0;
      max_nap_q <= 16'd60;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ra_q     <= ra_d;
      k_q      <= k_d;
      v_q      <= v_d;
      found_q  <= found_d;
      pv_q     <= pv_d;
      hn_q     <= hn_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        max_nap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obj_q   <= obj_d;
    exp_q   <= exp_d;
    now_q   <= now_d;
    di_q    <= di_d;
    pt_q    <= pt_d;
    po_q    <= po_d;
    nt_q    <= nt_d;
    kind_q  <= kind_d;
    aobj_q  <= aobj_d;
    atime_q <= atime_d;
    se_q    <= se_d;
    nap_q   <= nap_d;
    qf_q    <= qf_d;
    last_q  <= last_d;
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign alert_object_o  = aobj_q;
  assign alert_time_o    = atime_q;
  assign second_end_o    = se_q;
  assign nap_o           = nap_q;
  assign queue_full_o    = qf_q;
  assign last_o          = last_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("An accepted transaction did not make the unit busy.");

  a_alert_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && (kind_q == stq_pkg::KIND_ALERT)) |-> !last_q)
    else $error("An alert was marked as the final result.");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ({1'b0, wa} < (AW + 1)'(QUEUE_DEPTH)))
    else $error("Memory write beyond the queue depth.");

  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::ST_IDLE) |-> (!we && !v_q))
    else $error("Memory activity while idle.");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sorted timer queue with its own queue predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  obj;
    logic [31:0] etime;
    logic        sec_end;
    logic [15:0] nap;
    logic        full;
    logic        last;
  } timer_result_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  obj;
    logic [31:0] expiry;
    logic [31:0] now;
    logic        nap_known;
    logic [15:0] nap_value;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = stq_pkg::OP_SET;
  logic [7:0]  object_id_i = '0;
  logic [31:0] expiry_time_i = '0;
  logic [31:0] now_time_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        result_strobe_o;
  logic [1:0]  kind_o;
  logic [7:0]  alert_object_o;
  logic [31:0] alert_time_o;
  logic        second_end_o;
  logic [15:0] nap_o;
  logic        queue_full_o;
  logic        last_o;

  logic [31:0]   timer_time[DEPTH];
  logic [7:0]    timer_obj[DEPTH];
  int            timer_count;
  logic [15:0]   nap_cap;
  timer_result_t pending_results[$];
  int            error_count;
  int            items_sent;
  int            results_seen;
  int            alerts_seen;
  int            full_seen;
  int            stall_cycles;
  logic [31:0]   sim_sec;
  stim_row_t     dir_rows[13];

  sorted_timer_queue_unit #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk_i, .rst_ni, .start, .busy, .op_i, .object_id_i, .expiry_time_i, .now_time_i,
    .cfg_we_i, .cfg_wdata_i, .result_strobe_o, .kind_o, .alert_object_o, .alert_time_o,
    .second_end_o, .nap_o, .queue_full_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_result(logic [1:0] kind, logic [7:0] obj, logic [31:0] t,
                                      logic se, logic [15:0] nap, logic qf, logic lst);
    timer_result_t r;
    r.kind = kind;
    r.obj = obj;
    r.etime = t;
    r.sec_end = se;
    r.nap = nap;
    r.full = qf;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_timer(int idx);
    for (int j = idx; j < timer_count - 1; j++) begin
      timer_time[j] = timer_time[j + 1];
      timer_obj[j] = timer_obj[j + 1];
    end
    timer_count--;
  endfunction

  function automatic void predict_timers(logic op, logic [7:0] obj, logic [31:0] expiry,
                                         logic [31:0] now);
    int          slot;
    logic [31:0] t;
    logic [7:0]  o;
    logic [31:0] diff;
    if (op == stq_pkg::OP_SET) begin
      for (int j = 0; j < timer_count; j++) begin
        if (timer_obj[j] == obj) begin
          drop_timer(j);
          break;
        end
      end
      if (expiry == 0) begin
        push_result(stq_pkg::KIND_ACK, '0, '0, 1'b0, '0, 1'b0, 1'b1);
      end else if (timer_count >= DEPTH) begin
        push_result(stq_pkg::KIND_ACK, '0, '0, 1'b0, '0, 1'b1, 1'b1);
      end else begin
        slot = 0;
        while (slot < timer_count && expiry >= timer_time[slot]) slot++;
        for (int j = timer_count; j > slot; j--) begin
          timer_time[j] = timer_time[j - 1];
          timer_obj[j] = timer_obj[j - 1];
        end
        timer_time[slot] = expiry;
        timer_obj[slot] = obj;
        timer_count++;
        push_result(stq_pkg::KIND_ACK, '0, '0, 1'b0, '0, 1'b0, 1'b1);
      end
    end else begin
      while (timer_count > 0 && timer_time[0] <= now) begin
        t = timer_time[0];
        o = timer_obj[0];
        drop_timer(0);
        push_result(stq_pkg::KIND_ALERT, o, t, (timer_count == 0 || timer_time[0] != t),
                    '0, 1'b0, 1'b0);
      end
      if (timer_count == 0) begin
        push_result(stq_pkg::KIND_NAP, '0, '0, 1'b0, nap_cap, 1'b0, 1'b1);
      end else begin
        diff = timer_time[0] - now;
        push_result(stq_pkg::KIND_NAP, '0, '0, 1'b0,
                    (diff > {16'd0, nap_cap}) ? nap_cap : diff[15:0], 1'b0, 1'b1);
      end
    end
  endfunction

  task automatic issue(logic op, logic [7:0] obj, logic [31:0] expiry, logic [31:0] now,
                       int idle_pct);
    start <= 1'b1;
    op_i <= op;
    object_id_i <= obj;
    expiry_time_i <= expiry;
    now_time_i <= now;
    do @(posedge clk_i); while (busy);
    predict_timers(op, obj, expiry, now);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_nap_cap(logic [15:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nap_cap = value;
  endtask

  function automatic logic [7:0] pick_object();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(0, 47)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(int count, int idle_pct, bit pause_midway);
    logic [31:0] expiry;
    logic [31:0] now;
    int          pick;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        issue(stq_pkg::OP_SET, pick_object(), 32'd0, $urandom, idle_pct);
      end else if (pick < 60) begin
        expiry = ($urandom_range(99) < 5) ? $urandom : sim_sec + $urandom_range(0, 120);
        issue(stq_pkg::OP_SET, pick_object(), expiry, $urandom, idle_pct);
      end else begin
        sim_sec += $urandom_range(0, 40);
        now = ($urandom_range(99) < 5) ? $urandom : sim_sec;
        issue(stq_pkg::OP_TICK, 8'($urandom), $urandom, now, idle_pct);
      end
    end
  endtask

  always @(posedge clk_i) begin
    timer_result_t e;
    if (rst_ni && result_strobe_o) begin
      results_seen++;
      if (kind_o == stq_pkg::KIND_ALERT) alerts_seen++;
      if (queue_full_o) full_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, kind_o);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (e.kind !== kind_o || e.obj !== alert_object_o || e.etime !== alert_time_o ||
            e.sec_end !== second_end_o || e.nap !== nap_o || e.full !== queue_full_o ||
            e.last !== last_o) begin
          $display("%0t: expected kind %0d obj %0d time %0d se %0d nap %0d full %0d last %0d",
                   $time, e.kind, e.obj, e.etime, e.sec_end, e.nap, e.full, e.last);
          $display("%0t: actual   kind %0d obj %0d time %0d se %0d nap %0d full %0d last %0d",
                   $time, kind_o, alert_object_o, alert_time_o, second_end_o, nap_o,
                   queue_full_o, last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    timer_count = 0;
    nap_cap = 16'd60;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    alerts_seen = 0;
    full_seen = 0;
    sim_sec = 32'd1000;
    dir_rows[0]  = '{stq_pkg::OP_TICK, 8'd0,   32'd0,         32'd0,         1'b1, 16'd60};
    dir_rows[1]  = '{stq_pkg::OP_SET,  8'd0,   32'd100,       32'hFFFF_FFFF, 1'b0, 16'd0};
    dir_rows[2]  = '{stq_pkg::OP_SET,  8'd255, 32'd100,       32'd0,         1'b0, 16'd0};
    dir_rows[3]  = '{stq_pkg::OP_SET,  8'd7,   32'hFFFF_FFFF, 32'd0,         1'b0, 16'd0};
    dir_rows[4]  = '{stq_pkg::OP_SET,  8'd0,   32'd50,        32'd0,         1'b0, 16'd0};
    dir_rows[5]  = '{stq_pkg::OP_SET,  8'd9,   32'd0,         32'd0,         1'b0, 16'd0};
    dir_rows[6]  = '{stq_pkg::OP_TICK, 8'd0,   32'd0,         32'd10,        1'b1, 16'd40};
    dir_rows[7]  = '{stq_pkg::OP_TICK, 8'hFF,  32'hFFFF_FFFF, 32'd100,       1'b1, 16'd60};
    dir_rows[8]  = '{stq_pkg::OP_SET,  8'd7,   32'd0,         32'd0,         1'b0, 16'd0};
    dir_rows[9]  = '{stq_pkg::OP_TICK, 8'd0,   32'd0,         32'hFFFF_FFFF, 1'b1, 16'd60};
    dir_rows[10] = '{stq_pkg::OP_SET,  8'd3,   32'd5,         32'd0,         1'b0, 16'd0};
    dir_rows[11] = '{stq_pkg::OP_SET,  8'd4,   32'd5,         32'd0,         1'b0, 16'd0};
    dir_rows[12] = '{stq_pkg::OP_TICK, 8'hAA,  32'h5555_5555, 32'hFFFF_FFFF, 1'b1, 16'd60};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      issue(dir_rows[r].op, dir_rows[r].obj, dir_rows[r].expiry, dir_rows[r].now, 0);
      if (dir_rows[r].nap_known)
        pending_results[pending_results.size() - 1].nap = dir_rows[r].nap_value;
    end

    // Fill the queue past its depth, cancel one timer and set a later one, then drain the queue with two ticks.
    write_nap_cap(16'd1);
    for (int n = 0; n < DEPTH + 2; n++)
      issue(stq_pkg::OP_SET, 8'(100 + n), 32'd20 + 32'(n % 5), 32'd0, 0);
    issue(stq_pkg::OP_SET, 8'd100, 32'd0, 32'd0, 0);
    issue(stq_pkg::OP_SET, 8'd200, 32'd30, 32'd0, 0);
    issue(stq_pkg::OP_TICK, 8'd0, 32'd0, 32'd25, 0);
    issue(stq_pkg::OP_TICK, 8'd0, 32'd0, 32'd30, 0);

    write_nap_cap(16'hFFFF);
    run_phase(57, 19, 1'b0);
    write_nap_cap(16'd0);
    run_phase(57, 66, 1'b1);
    write_nap_cap(16'($urandom_range(1, 65535)));
    run_phase(57, 0, 1'b0);

    drain_results();
    $display("Sent %0d transactions; checked %0d results, %0d alerts, %0d full-queue drops.",
             items_sent, results_seen, alerts_seen, full_seen);
    $display("Max nap settings covered 60, 1, 65535, 0 and a random value.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
